// ----- design/fpd_pkg.sv -----
// Shared types, constants and the CORDIC arctangent table for the PLL FM demodulator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package fpd_pkg;

	localparam int SAMPLE_BITS     = 16;
	localparam int PHASE_BITS_DEF  = 24;
	localparam int ANGLE_W         = 32;
	localparam int CORDIC_STEPS    = 29;
	localparam int STEP_W          = 5;
	localparam int FREQ_W          = 24;
	localparam int DC_W            = 40;
	localparam int GAIN_W          = 18;
	localparam int LIMIT_W         = 23;
	localparam int FRAC_W          = 24;
	localparam int HALF_W          = 12;
	localparam int MUL_A_W         = 42;
	localparam int MUL_B_W         = 19;
	localparam int MUL_P_W         = MUL_A_W + MUL_B_W;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INT_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FREQ_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DC_GAIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_GAIN = 3'd4;

	localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 18'd72786;
	localparam logic [GAIN_W-1:0]  INT_GAIN_RST   = 18'd40427;
	localparam logic [LIMIT_W-1:0] FREQ_LIMIT_RST = 23'd2097152;
	localparam logic [FRAC_W-1:0]  DC_GAIN_RST    = 24'd34917;
	localparam logic [FRAC_W-1:0]  AUDIO_GAIN_RST = 24'd200000;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] i_sample;
		logic signed [SAMPLE_BITS-1:0] q_sample;
		logic                          block_end;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] audio_out;
		logic                          block_end_out;
	} audio_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  prop_gain;
		logic [GAIN_W-1:0]  int_gain;
		logic [LIMIT_W-1:0] freq_limit;
		logic [FRAC_W-1:0]  dc_gain;
		logic [FRAC_W-1:0]  audio_gain;
	} cfg_t;

	// atan(2^-i) in 32-bit turns
	function automatic logic [ANGLE_W-1:0] atan_turn(input logic [STEP_W-1:0] idx);
		logic [ANGLE_W-1:0] t;
		case (idx)
			5'd0:  t = 32'd536870912;
			5'd1:  t = 32'd316933406;
			5'd2:  t = 32'd167458907;
			5'd3:  t = 32'd85004756;
			5'd4:  t = 32'd42667331;
			5'd5:  t = 32'd21354465;
			5'd6:  t = 32'd10679838;
			5'd7:  t = 32'd5340245;
			5'd8:  t = 32'd2670163;
			5'd9:  t = 32'd1335087;
			5'd10: t = 32'd667544;
			5'd11: t = 32'd333772;
			5'd12: t = 32'd166886;
			5'd13: t = 32'd83443;
			5'd14: t = 32'd41722;
			5'd15: t = 32'd20861;
			5'd16: t = 32'd10430;
			5'd17: t = 32'd5215;
			5'd18: t = 32'd2608;
			5'd19: t = 32'd1304;
			5'd20: t = 32'd652;
			5'd21: t = 32'd326;
			5'd22: t = 32'd163;
			5'd23: t = 32'd81;
			5'd24: t = 32'd41;
			5'd25: t = 32'd20;
			5'd26: t = 32'd10;
			5'd27: t = 32'd5;
			5'd28: t = 32'd3;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

// ----- design/fpd_cordic.sv -----
// Iterative vectoring CORDIC: angle of (I, Q) in 32-bit turns, one micro-rotation per cycle.
// Depends on fpd_pkg.
`timescale 1ns / 1ps

module fpd_cordic (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [fpd_pkg::SAMPLE_BITS-1:0] i_in,
	input  logic signed [fpd_pkg::SAMPLE_BITS-1:0] q_in,
	output logic                                  done,
	output logic [fpd_pkg::ANGLE_W-1:0]           angle
);

	localparam int XW = fpd_pkg::SAMPLE_BITS + 19;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t                          state_q;
	logic [fpd_pkg::STEP_W-1:0]      step_q;
	logic                            done_q;
	logic                            zero_q;
	logic signed [XW-1:0]            x_q;
	logic signed [XW-1:0]            y_q;
	logic [fpd_pkg::ANGLE_W-1:0]     z_q;

	logic signed [XW-1:0] xl, yl, xs, ys;
	logic [fpd_pkg::ANGLE_W-1:0] at;

	assign xl = XW'(i_in) <<< 16;
	assign yl = XW'(q_in) <<< 16;
	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign at = fpd_pkg::atan_turn(step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					if (step_q == fpd_pkg::STEP_W'(fpd_pkg::CORDIC_STEPS - 1)) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
					step_q <= step_q + 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			zero_q <= (i_in == '0) && (q_in == '0);
			if (i_in < 0) begin
				x_q <= -xl;
				y_q <= -yl;
				z_q <= {1'b1, {(fpd_pkg::ANGLE_W-1){1'b0}}};
			end else begin
				x_q <= xl;
				y_q <= yl;
				z_q <= '0;
			end
		end else if (state_q == ST_RUN) begin
			if (!y_q[XW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	assign done  = done_q;
	assign angle = zero_q ? '0 : z_q;

endmodule

// ----- design/fpd_mac.sv -----
// Shared signed multiplier with registered product, used for every loop, DC and audio term.
// Depends on fpd_pkg.
`timescale 1ns / 1ps

module fpd_mac (
	input  logic                                 clk,
	input  logic signed [fpd_pkg::MUL_A_W-1:0]   a,
	input  logic signed [fpd_pkg::MUL_B_W-1:0]   b,
	output logic signed [fpd_pkg::MUL_P_W-1:0]   prod
);

	logic signed [fpd_pkg::MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= fpd_pkg::MUL_P_W'(a) * fpd_pkg::MUL_P_W'(b);
	end

	assign prod = prod_q;

endmodule

// ----- design/fpd_loop.sv -----
// Loop filter, NCO, DC tracker and audio scaling, sequenced over the shared multiplier.
// Depends on fpd_pkg and fpd_mac.
`timescale 1ns / 1ps

module fpd_loop #(
	parameter int PHASE_BITS = fpd_pkg::PHASE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [fpd_pkg::ANGLE_W-1:0]            angle,
	input  fpd_pkg::cfg_t                          cfg,
	input  logic                                   take,
	output logic                                   res_valid,
	output logic signed [fpd_pkg::SAMPLE_BITS-1:0] audio
);

	localparam int FSW = PHASE_BITS + 4;
	localparam int PW  = fpd_pkg::MUL_P_W;
	localparam int HW  = fpd_pkg::HALF_W;
	localparam logic signed [PW-1:0] SMAX = PW'((64'sd1 <<< (fpd_pkg::SAMPLE_BITS - 1)) - 1);
	localparam logic signed [PW-1:0] SMIN = -SMAX - 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_I,
		ST_UPD_F,
		ST_UPD_P,
		ST_DC_HI,
		ST_UPD_D,
		ST_AU_LO,
		ST_AU_HI,
		ST_UPD_A,
		ST_DONE
	} state_t;

	state_t                                 state_q;
	logic                                   res_valid_q;
	logic [PHASE_BITS-1:0]                  phase_q;
	logic signed [fpd_pkg::FREQ_W-1:0]      freq_q;
	logic signed [fpd_pkg::DC_W-1:0]        dc_q;
	logic signed [PHASE_BITS-1:0]           err_q;
	logic signed [PW-1:0]                   lo_q;
	logic signed [fpd_pkg::SAMPLE_BITS-1:0] audio_q;

	logic signed [fpd_pkg::MUL_A_W-1:0] mul_a;
	logic signed [fpd_pkg::MUL_B_W-1:0] mul_b;
	logic signed [PW-1:0]               prod;
	logic signed [fpd_pkg::MUL_A_W-1:0] diff;
	logic [PHASE_BITS-1:0]              theta;
	logic signed [FSW-1:0]              fsum, lim;
	logic signed [PW-1:0]               wide_sum, scaled;

	fpd_mac u_mac (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign theta    = angle[fpd_pkg::ANGLE_W-1 -: PHASE_BITS];
	assign diff     = fpd_pkg::MUL_A_W'($signed({freq_q, 16'b0})) - fpd_pkg::MUL_A_W'(dc_q);
	assign fsum     = FSW'(freq_q) + FSW'(prod >>> 16);
	assign lim      = FSW'($signed({1'b0, cfg.freq_limit}));
	assign wide_sum = prod + (lo_q >>> HW);
	assign scaled   = wide_sum >>> (2 * HW + 4);

	always_comb begin
		mul_a = diff;
		mul_b = '0;
		case (state_q)
			ST_MUL_I: begin
				mul_a = fpd_pkg::MUL_A_W'(err_q);
				mul_b = $signed({1'b0, cfg.int_gain});
			end
			ST_UPD_F: begin
				mul_a = fpd_pkg::MUL_A_W'(err_q);
				mul_b = $signed({1'b0, cfg.prop_gain});
			end
			ST_UPD_P: mul_b = $signed(fpd_pkg::MUL_B_W'(cfg.dc_gain[HW-1:0]));
			ST_DC_HI: mul_b = $signed(fpd_pkg::MUL_B_W'(cfg.dc_gain[2*HW-1:HW]));
			ST_AU_LO: mul_b = $signed(fpd_pkg::MUL_B_W'(cfg.audio_gain[HW-1:0]));
			ST_AU_HI: mul_b = $signed(fpd_pkg::MUL_B_W'(cfg.audio_gain[2*HW-1:HW]));
			default: mul_b = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			phase_q     <= '0;
			freq_q      <= '0;
			dc_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MUL_I;
					end
				end
				ST_MUL_I: state_q <= ST_UPD_F;
				ST_UPD_F: begin
					if (fsum > lim) begin
						freq_q <= fpd_pkg::FREQ_W'(lim);
					end else if (fsum < -lim) begin
						freq_q <= fpd_pkg::FREQ_W'(-lim);
					end else begin
						freq_q <= fpd_pkg::FREQ_W'(fsum);
					end
					state_q <= ST_UPD_P;
				end
				ST_UPD_P: begin
					phase_q <= phase_q + PHASE_BITS'(freq_q) + PHASE_BITS'(prod >>> 16);
					state_q <= ST_DC_HI;
				end
				ST_DC_HI: state_q <= ST_UPD_D;
				ST_UPD_D: begin
					dc_q    <= dc_q + fpd_pkg::DC_W'(wide_sum >>> HW);
					state_q <= ST_AU_LO;
				end
				ST_AU_LO: state_q <= ST_AU_HI;
				ST_AU_HI: state_q <= ST_UPD_A;
				ST_UPD_A: begin
					if (scaled > SMAX) begin
						audio_q <= fpd_pkg::SAMPLE_BITS'(SMAX);
					end else if (scaled < SMIN) begin
						audio_q <= fpd_pkg::SAMPLE_BITS'(SMIN);
					end else begin
						audio_q <= fpd_pkg::SAMPLE_BITS'(scaled);
					end
					res_valid_q <= 1'b1;
					state_q     <= ST_DONE;
				end
				ST_DONE: begin
					if (take) begin
						res_valid_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			err_q <= $signed(PHASE_BITS'(0) - (theta + phase_q));
		end
		if (state_q == ST_DC_HI || state_q == ST_AU_HI) begin
			lo_q <= prod;
		end
	end

	assign res_valid = res_valid_q;
	assign audio     = audio_q;

endmodule

// ----- design/fm_pll_demodulator_top.sv -----
// PLL FM demodulator top level: channels, configuration registers and the output register.
// Depends on fpd_pkg, fpd_cordic, fpd_loop (and fpd_mac below it).
//
// Usage:
//   sample channel: sample_valid / sample_stall, payload sample (I, Q, block_end).
//   audio channel:  audio_valid / audio_stall, payload audio (audio_out, block_end_out).
//   A request moves when valid is high and stall is low at a rising edge.
//   cfg channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is always
//   high. Write registers only while the block is idle.
//   From sample acceptance to audio_valid a sample passes 29 CORDIC steps, a handoff,
//   8 loop-sequencer steps that share one multiplier, and the output load.
//   A new sample is accepted only once the last result has moved into the output
//   register; sample_stall stays high until then.
//   A finished result waits in the output register while the next sample runs; if the
//   receiver still stalls when that next result is done, the sequencer holds it.
//   Reset clears NCO phase, frequency and DC level, and loads register defaults.
`timescale 1ns / 1ps

module fm_pll_demodulator_top #(
	parameter int PHASE_BITS = fpd_pkg::PHASE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  fpd_pkg::sample_t                  sample,
	output logic                              audio_valid,
	input  logic                              audio_stall,
	output fpd_pkg::audio_t                   audio,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fpd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fpd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	fpd_pkg::cfg_t   cfg_q;
	fpd_pkg::audio_t audio_q;
	logic            audio_valid_q;
	logic            busy_q;
	logic            block_end_q;

	logic                                   accept;
	logic                                   cordic_done;
	logic [fpd_pkg::ANGLE_W-1:0]            angle;
	logic                                   res_valid;
	logic signed [fpd_pkg::SAMPLE_BITS-1:0] res_audio;
	logic                                   take;

	assign sample_stall = busy_q;
	assign accept       = sample_valid && !busy_q;
	assign take         = res_valid && (!audio_valid_q || !audio_stall);
	assign cfg_ready    = 1'b1;

	fpd_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.i_in   (sample.i_sample),
		.q_in   (sample.q_sample),
		.done   (cordic_done),
		.angle  (angle)
	);

	fpd_loop #(
		.PHASE_BITS (PHASE_BITS)
	) u_loop (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cordic_done),
		.angle     (angle),
		.cfg       (cfg_q),
		.take      (take),
		.res_valid (res_valid),
		.audio     (res_audio)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain  <= fpd_pkg::PROP_GAIN_RST;
			cfg_q.int_gain   <= fpd_pkg::INT_GAIN_RST;
			cfg_q.freq_limit <= fpd_pkg::FREQ_LIMIT_RST;
			cfg_q.dc_gain    <= fpd_pkg::DC_GAIN_RST;
			cfg_q.audio_gain <= fpd_pkg::AUDIO_GAIN_RST;
			busy_q           <= 1'b0;
			audio_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					fpd_pkg::CFG_PROP_GAIN:  cfg_q.prop_gain  <= cfg_data[fpd_pkg::GAIN_W-1:0];
					fpd_pkg::CFG_INT_GAIN:   cfg_q.int_gain   <= cfg_data[fpd_pkg::GAIN_W-1:0];
					fpd_pkg::CFG_FREQ_LIMIT: cfg_q.freq_limit <= cfg_data[fpd_pkg::LIMIT_W-1:0];
					fpd_pkg::CFG_DC_GAIN:    cfg_q.dc_gain    <= cfg_data[fpd_pkg::FRAC_W-1:0];
					fpd_pkg::CFG_AUDIO_GAIN: cfg_q.audio_gain <= cfg_data[fpd_pkg::FRAC_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (take) begin
				busy_q <= 1'b0;
			end
			if (take) begin
				audio_valid_q <= 1'b1;
			end else if (!audio_stall) begin
				audio_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			block_end_q <= sample.block_end;
		end
		if (take) begin
			audio_q.audio_out     <= res_audio;
			audio_q.block_end_out <= block_end_q;
		end
	end

	assign audio_valid = audio_valid_q;
	assign audio       = audio_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> sample_stall)
		else $error("sample accepted but block not marked busy");

	a_cordic_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		cordic_done |-> (busy_q && !res_valid))
		else $error("CORDIC finished outside of a request in work");

	a_take_shows: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (audio_valid && !res_valid && !sample_stall))
		else $error("result handoff did not load the output register");

	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> busy_q)
		else $error("result pending while block idle");

endmodule

// ----- dv/fm_pll_demodulator_top_test.sv -----
// Self-checking testbench for fm_pll_demodulator_top: random FM tones and noise through the
// sample channel, audio checked against a bit-exact loop model. Needs fpd_pkg and the design.
`timescale 1ns / 1ps

module fm_pll_demodulator_top_test;

	localparam int  N_PHASES     = 6;
	localparam int  RAND_PER_PH  = 125;
	localparam real TWO_PI       = 6.283185307179586;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           sample_valid;
	logic                           sample_stall;
	fpd_pkg::sample_t               sample;
	logic                           audio_valid;
	logic                           audio_stall;
	fpd_pkg::audio_t                audio;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [fpd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [fpd_pkg::CFG_DATA_W-1:0] cfg_data;

	fm_pll_demodulator_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.audio_valid  (audio_valid),
		.audio_stall  (audio_stall),
		.audio        (audio),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	fpd_pkg::sample_t feed_q[$];
	fpd_pkg::audio_t  audio_expected[$];
	int      n_sent;
	int      n_taken;
	int      n_errors;
	int      send_idle_pct;
	int      recv_stall_pct;

	// loop model state and register copy
	longint         atan_tab[fpd_pkg::CORDIC_STEPS];
	logic [23:0]    loop_ph;
	longint         loop_fr;
	longint         dc_lvl;
	longint         g_prop, g_int, f_lim, g_dc, g_aud;

	// tone generator
	real fm_ph, fm_mod_ph, fm_dev, fm_rate, fm_off, fm_amp;

	function automatic logic [31:0] sample_angle(longint xi, longint yq);
		longint      x, y, xs, ys;
		logic [31:0] z;
		z = '0;
		if (xi == 0 && yq == 0)
			return '0;
		x = xi * 65536;
		y = yq * 65536;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h8000_0000;
		end
		for (int i = 0; i < fpd_pkg::CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + atan_tab[i][31:0];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - atan_tab[i][31:0];
			end
		end
		return z;
	endfunction

	function automatic longint scale_q24(longint v, longint g);
		longint hi, lo;
		hi = v * (g >>> 12);
		lo = v * (g & 64'hFFF);
		return (hi + (lo >>> 12)) >>> 12;
	endfunction

	function automatic fpd_pkg::audio_t demod_sample(fpd_pkg::sample_t s);
		fpd_pkg::audio_t a;
		logic [31:0]     ang;
		logic [23:0]     err_raw;
		longint          err, prop_term, diff, aud;
		ang = sample_angle(longint'(s.i_sample), longint'(s.q_sample));
		err_raw = -(ang[31:8] + loop_ph);
		err = longint'(signed'(err_raw));
		loop_fr = loop_fr + ((err * g_int) >>> 16);
		if (loop_fr > f_lim)
			loop_fr = f_lim;
		else if (loop_fr < -f_lim)
			loop_fr = -f_lim;
		prop_term = (err * g_prop) >>> 16;
		loop_ph = loop_ph + loop_fr[23:0] + prop_term[23:0];
		dc_lvl = dc_lvl + scale_q24(loop_fr * 65536 - dc_lvl, g_dc);
		diff = loop_fr * 65536 - dc_lvl;
		aud = scale_q24(diff, g_aud) >>> 16;
		if (aud > 32767)
			aud = 32767;
		else if (aud < -32768)
			aud = -32768;
		a.audio_out = aud[15:0];
		a.block_end_out = s.block_end;
		return a;
	endfunction

	function automatic void new_tone();
		fm_off = ($itor($urandom_range(2000)) - 1000.0) / 20000.0;
		fm_dev = $itor($urandom_range(1000)) / 20000.0;
		fm_rate = $itor($urandom_range(200, 1)) / 1000.0;
		if ($urandom_range(4) == 0)
			fm_amp = $itor($urandom_range(60, 1));
		else
			fm_amp = $itor($urandom_range(32767, 200));
	endfunction

	function automatic fpd_pkg::sample_t next_sample();
		fpd_pkg::sample_t s;
		int      r;
		int      pick;
		logic signed [15:0] edge_vals[5];
		edge_vals = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1, 16'sd1};
		r = $urandom_range(99);
		if (r < 78) begin
			fm_ph = fm_ph + fm_off + fm_dev * $sin(TWO_PI * fm_mod_ph);
			fm_ph = fm_ph - $floor(fm_ph);
			fm_mod_ph = fm_mod_ph + fm_rate;
			fm_mod_ph = fm_mod_ph - $floor(fm_mod_ph);
			s.i_sample = 16'($rtoi(fm_amp * $cos(TWO_PI * fm_ph)));
			s.q_sample = 16'($rtoi(fm_amp * $sin(TWO_PI * fm_ph)));
		end else if (r < 93) begin
			s.i_sample = 16'($urandom_range(65535));
			s.q_sample = 16'($urandom_range(65535));
		end else begin
			pick = $urandom_range(4);
			s.i_sample = edge_vals[pick];
			pick = $urandom_range(4);
			s.q_sample = edge_vals[pick];
		end
		s.block_end = ($urandom_range(7) == 0);
		return s;
	endfunction

	// sample driver
	always @(negedge clk) begin
		if (arst_n && n_sent == n_taken) begin
			if (feed_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				sample <= feed_q.pop_front();
				sample_valid <= 1'b1;
				n_sent++;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			audio_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// request capture and audio check
	always @(posedge clk) begin
		fpd_pkg::audio_t exp_a;
		if (arst_n) begin
			if (sample_valid && !sample_stall) begin
				audio_expected.push_back(demod_sample(sample));
				n_taken++;
			end
			if (audio_valid && !audio_stall) begin
				if (audio_expected.size() == 0) begin
					$display("%0t: unexpected audio request, actual %0d/%0b", $time,
						audio.audio_out, audio.block_end_out);
					n_errors++;
				end else begin
					exp_a = audio_expected.pop_front();
					if (audio.audio_out !== exp_a.audio_out) begin
						$display("%0t: audio_out expected %0d, actual %0d", $time,
							exp_a.audio_out, audio.audio_out);
						n_errors++;
					end
					if (audio.block_end_out !== exp_a.block_end_out) begin
						$display("%0t: block_end_out expected %0b, actual %0b", $time,
							exp_a.block_end_out, audio.block_end_out);
						n_errors++;
					end
				end
			end
		end
	end

	task automatic write_reg(input logic [fpd_pkg::CFG_IDX_W-1:0] idx,
		input logic [fpd_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			fpd_pkg::CFG_PROP_GAIN:  g_prop = longint'(val[fpd_pkg::GAIN_W-1:0]);
			fpd_pkg::CFG_INT_GAIN:   g_int = longint'(val[fpd_pkg::GAIN_W-1:0]);
			fpd_pkg::CFG_FREQ_LIMIT: f_lim = longint'(val[fpd_pkg::LIMIT_W-1:0]);
			fpd_pkg::CFG_DC_GAIN:    g_dc = longint'(val[fpd_pkg::FRAC_W-1:0]);
			fpd_pkg::CFG_AUDIO_GAIN: g_aud = longint'(val[fpd_pkg::FRAC_W-1:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (feed_q.size() != 0 || n_sent != n_taken || audio_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic push_iq(input int i_v, input int q_v, input logic be);
		fpd_pkg::sample_t s;
		s.i_sample = 16'(i_v);
		s.q_sample = 16'(q_v);
		s.block_end = be;
		feed_q.push_back(s);
	endtask

	initial begin
		int stall_tab[N_PHASES];
		int idle_tab[N_PHASES];
		idle_tab = '{0, 48, 0, 22, 0, 22};
		stall_tab = '{0, 0, 48, 22, 0, 48};
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		audio_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		n_sent = 0;
		n_taken = 0;
		n_errors = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < fpd_pkg::CORDIC_STEPS; i++)
			atan_tab[i] = longint'($rtoi($atan(2.0 ** (-i)) / TWO_PI * 4294967296.0 + 0.5));
		loop_ph = '0;
		loop_fr = 0;
		dc_lvl = 0;
		g_prop = longint'(fpd_pkg::PROP_GAIN_RST);
		g_int = longint'(fpd_pkg::INT_GAIN_RST);
		f_lim = longint'(fpd_pkg::FREQ_LIMIT_RST);
		g_dc = longint'(fpd_pkg::DC_GAIN_RST);
		g_aud = longint'(fpd_pkg::AUDIO_GAIN_RST);
		fm_ph = 0.0;
		fm_mod_ph = 0.0;
		new_tone();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: begin
					// reset defaults, then directed corners
					push_iq(0, 0, 1'b0);
					push_iq(0, 0, 1'b1);
					push_iq(32767, 0, 1'b0);
					push_iq(-32768, 0, 1'b1);
					push_iq(0, 32767, 1'b0);
					push_iq(0, -32768, 1'b0);
					push_iq(32767, 32767, 1'b1);
					push_iq(-32768, -32768, 1'b0);
					push_iq(-32768, 32767, 1'b0);
					push_iq(32767, -32768, 1'b1);
					push_iq(-1, 0, 1'b0);
					push_iq(-1, -1, 1'b0);
					push_iq(1, 1, 1'b0);
					push_iq(0, -1, 1'b1);
					push_iq(-32768, 1, 1'b0);
					push_iq(-32768, -1, 1'b0);
					push_iq(1, 0, 1'b0);
					push_iq(0, 0, 1'b0);
					push_iq(-21846, 21845, 1'b1);
					push_iq(-1, 32767, 1'b0);
				end
				1: begin
					write_reg(fpd_pkg::CFG_PROP_GAIN, 24'd262143);
					write_reg(fpd_pkg::CFG_INT_GAIN, 24'd262143);
					write_reg(fpd_pkg::CFG_FREQ_LIMIT, 24'd8388607);
					write_reg(fpd_pkg::CFG_DC_GAIN, 24'hFFFFFF);
					write_reg(fpd_pkg::CFG_AUDIO_GAIN, 24'hFFFFFF);
				end
				2: begin
					// limit dropped below the running frequency; upper data bits masked
					write_reg(fpd_pkg::CFG_FREQ_LIMIT, 24'd1000);
					write_reg(fpd_pkg::CFG_PROP_GAIN, 24'hFC0000 | 24'd50000);
					write_reg(fpd_pkg::CFG_INT_GAIN, 24'd20000);
					write_reg(fpd_pkg::CFG_AUDIO_GAIN, 24'd8000000);
				end
				3: begin
					write_reg(fpd_pkg::CFG_PROP_GAIN, '0);
					write_reg(fpd_pkg::CFG_INT_GAIN, '0);
					write_reg(fpd_pkg::CFG_FREQ_LIMIT, '0);
					write_reg(fpd_pkg::CFG_DC_GAIN, '0);
					write_reg(fpd_pkg::CFG_AUDIO_GAIN, '0);
				end
				4: begin
					write_reg(fpd_pkg::CFG_PROP_GAIN, 24'($urandom_range(262143)));
					write_reg(fpd_pkg::CFG_INT_GAIN, 24'($urandom_range(262143)));
					write_reg(fpd_pkg::CFG_FREQ_LIMIT, 24'($urandom_range(8388607)));
					write_reg(fpd_pkg::CFG_DC_GAIN, 24'($urandom_range(16777215)));
					write_reg(fpd_pkg::CFG_AUDIO_GAIN, 24'($urandom_range(16777215)));
					write_reg(3'd5, 24'h123456);
					write_reg(3'd7, 24'hFFFFFF);
				end
				default: begin
					write_reg(fpd_pkg::CFG_PROP_GAIN,
						fpd_pkg::CFG_DATA_W'(fpd_pkg::PROP_GAIN_RST));
					write_reg(fpd_pkg::CFG_INT_GAIN,
						fpd_pkg::CFG_DATA_W'(fpd_pkg::INT_GAIN_RST));
					write_reg(fpd_pkg::CFG_FREQ_LIMIT,
						fpd_pkg::CFG_DATA_W'(fpd_pkg::FREQ_LIMIT_RST));
					write_reg(fpd_pkg::CFG_DC_GAIN, 24'd2000000);
					write_reg(fpd_pkg::CFG_AUDIO_GAIN, 24'd4000000);
				end
			endcase
			send_idle_pct = idle_tab[ph];
			recv_stall_pct = stall_tab[ph];
			for (int k = 0; k < RAND_PER_PH; k++) begin
				if (k % 40 == 0)
					new_tone();
				feed_q.push_back(next_sample());
				// full drain mid-phase
				if (k == RAND_PER_PH / 2)
					drain();
			end
			drain();
		end

		repeat (60) @(posedge clk);
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule
